// File: rtl/core/rrl_pkg.sv
// ----------------------------------------------------------------------------
// rrl_pkg: shared types and codes for the robust recursive lock
// Request and result payloads, lock state, status and action codes.
// ----------------------------------------------------------------------------
package rrl_pkg;

  // Default depth limit handed to the top level
  localparam int MAX_DEPTH_DEFAULT = 255;

  // Action codes
  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Status codes
  localparam logic [2:0] ST_ACQUIRED  = 3'd0;
  localparam logic [2:0] ST_REENTERED = 3'd1;
  localparam logic [2:0] ST_RECLAIMED = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_PARTIAL   = 3'd4;
  localparam logic [2:0] ST_FREED     = 3'd5;
  localparam logic [2:0] ST_NOT_OWNER = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  typedef struct packed {
    logic        action;
    logic [31:0] requester_process;
    logic [31:0] requester_thread;
    logic        owner_alive;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        granted;
    logic [31:0] holder_process;
    logic [7:0]  depth_now;
    logic [31:0] epoch_now;
    logic        held_by_process;
    logic        held_by_thread;
  } result_t;

  typedef struct packed {
    logic [31:0] owner_process;
    logic [31:0] owner_thread;
    logic [7:0]  depth_count;
    logic [31:0] epoch;
  } lock_state_t;

endpackage

// File: rtl/core/rrl_decide.sv
// ----------------------------------------------------------------------------
// rrl_decide: lock decision logic
// Given the current lock state and one request, computes the next state and
// the result for that request.
// ----------------------------------------------------------------------------
module rrl_decide #(
  parameter int MAX_DEPTH = rrl_pkg::MAX_DEPTH_DEFAULT
) (
  input  rrl_pkg::lock_state_t cur,
  input  rrl_pkg::request_t    request,
  output rrl_pkg::lock_state_t nxt,
  output rrl_pkg::result_t     result
);
  import rrl_pkg::*;

  // Depth saturates at the smaller of the parameter and the counter range
  localparam logic [7:0] DepthLimit = (MAX_DEPTH < 255) ? 8'(MAX_DEPTH) : 8'd255;

  logic       rp_zero;
  logic       free;
  logic       same_proc;
  logic       same_thread;
  logic [2:0] status;
  logic       mine_p;

  assign rp_zero     = (request.requester_process == 32'd0);
  assign free        = (cur.owner_process == 32'd0);
  assign same_proc   = (cur.owner_process == request.requester_process);
  assign same_thread = (cur.owner_thread == request.requester_thread);

  // Request decision and state update
  always_comb begin
    nxt    = cur;
    status = ST_BUSY;
    if (request.action == ACT_ACQUIRE) begin
      if (rp_zero) begin
        status = ST_BUSY;
      end else if (free) begin
        nxt.owner_process = request.requester_process;
        nxt.owner_thread  = request.requester_thread;
        nxt.depth_count   = 8'd1;
        status            = ST_ACQUIRED;
      end else if (same_proc) begin
        if (!same_thread) begin
          status = ST_BUSY;
        end else if (cur.depth_count >= DepthLimit) begin
          status = ST_OVERFLOW;
        end else begin
          nxt.depth_count = cur.depth_count + 8'd1;
          status          = ST_REENTERED;
        end
      end else if (!request.owner_alive) begin
        // dead owner: take over and start a new generation
        nxt.owner_process = request.requester_process;
        nxt.owner_thread  = request.requester_thread;
        nxt.depth_count   = 8'd1;
        nxt.epoch         = cur.epoch + 32'd1;
        status            = ST_RECLAIMED;
      end else begin
        status = ST_BUSY;
      end
    end else begin
      if (rp_zero || free || !same_proc || !same_thread) begin
        status = ST_NOT_OWNER;
      end else if (cur.depth_count > 8'd1) begin
        nxt.depth_count = cur.depth_count - 8'd1;
        status          = ST_PARTIAL;
      end else begin
        nxt.owner_process = 32'd0;
        nxt.owner_thread  = 32'd0;
        nxt.depth_count   = 8'd0;
        nxt.epoch         = cur.epoch + 32'd1;
        status            = ST_FREED;
      end
    end
  end

  // Result fields reflect the state after the step
  assign mine_p = !rp_zero && (nxt.owner_process == request.requester_process);

  always_comb begin
    result.status          = status;
    result.granted         = !(status == ST_BUSY || status == ST_NOT_OWNER ||
                               status == ST_OVERFLOW);
    result.holder_process  = nxt.owner_process;
    result.depth_now       = nxt.depth_count;
    result.epoch_now       = nxt.epoch;
    result.held_by_process = mine_p;
    result.held_by_thread  = mine_p && (nxt.owner_thread == request.requester_thread);
  end

endmodule

// File: rtl/core/robust_recursive_lock.sv
// ----------------------------------------------------------------------------
// robust_recursive_lock: recursive lock register with owner recovery
// Pipeline: input register, then decision logic into the result register.
// Throughput: one request per cycle while the result channel does not stall;
//   the lock state loop closes through the decision logic.
// Reset: synchronous, clears the lock state (free, depth 0, epoch 0) and
//   both pipeline stages.
// ----------------------------------------------------------------------------
module robust_recursive_lock #(
  parameter int MAX_DEPTH = rrl_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  rrl_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_ready,
  output rrl_pkg::result_t  result
);
  import rrl_pkg::*;

  logic        in_valid;
  request_t    in_req;
  logic        advance;
  lock_state_t lock_state;
  lock_state_t lock_state_next;
  result_t     result_next;

  // Stage handshake: the input register drains when the result slot frees
  assign advance       = in_valid && (!result_valid || result_ready);
  assign request_ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request_ready) begin
      in_valid <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request_valid && request_ready) begin
      in_req <= request;
    end
  end

  rrl_decide #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_decide (
    .cur     (lock_state),
    .request (in_req),
    .nxt     (lock_state_next),
    .result  (result_next)
  );

  // Lock state, updated once per request leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_state <= '0;
    end else if (advance) begin
      lock_state <= lock_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/core/rrl_checker.sv
// ----------------------------------------------------------------------------
// rrl_checker: port-level checks for the robust recursive lock
// Watches the result channel and the consistency of reported lock state.
// ----------------------------------------------------------------------------
module rrl_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input rrl_pkg::result_t result
);
  import rrl_pkg::*;

  // No result comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A freed lock reports no holder and zero depth
  a_freed: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FREED) |->
      (result.holder_process == 32'd0) && (result.depth_now == 8'd0) &&
      !result.held_by_process && result.granted)
    else $error("freed result shows a holder");

  // A re-entry leaves the requesting thread holding at depth two or more
  a_reenter: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_REENTERED) |->
      result.held_by_thread && result.held_by_process && (result.depth_now >= 8'd2))
    else $error("re-entry result inconsistent");

endmodule

bind robust_recursive_lock rrl_checker u_rrl_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
